>>> rtl/rmst_pkg.sv
package rmst_pkg;

  localparam int VALUE_W = 31;
  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = {VALUE_W{1'b1}};

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   last_index;
    logic [VALUE_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] min_value;
    logic               range_error;
  } out_word_t;

endpackage

>>> rtl/range_minimum_segment_tree.sv
// Range-minimum segment tree over up to MAX_ELEMENTS 31-bit values.
// Input channel (in_valid/in_ready, in_data) takes one word per command:
//   update: writes new_value at first_index and rebuilds the path to the root;
//           no result. Ignored when first_index >= element count.
//   query:  one result word on the output channel (out_valid/out_ready,
//           out_data) with the minimum over [first_index, last_index], or
//           range_error=1 and min_value=0 for an empty or out-of-count range.
// The tree lives in one synchronous RAM of 2*MAX_ELEMENTS words with one
// read and one write port, read data registered and ready in the next cycle.
// Update: after accept, S_DEC decodes, S_UL writes the leaf and reads its
// sibling, then S_UP rebuilds one tree level a cycle up to the root.
// Query: after S_DEC, S_QA and S_QB alternate once per tree level walked, and
// the result is registered from S_QA; an invalid range finishes in the first S_QA.
// One command is worked at a time; in_ready is high only when idle.
// The result sits in an output register, so a new command is accepted while
// a result waits. A query that finishes while that register is still full
// holds until the receiver takes the earlier word.
// Reset clears all 2*MAX_ELEMENTS RAM words in one pass with in_ready low;
// element_count (cfg_we/cfg_data) resets to 1024 and is written at any time.
module range_minimum_segment_tree
  import rmst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = $clog2(DEPTH + 1);
  localparam int CW    = ($clog2(MAX_ELEMENTS + 1) > COUNT_W) ?
                         $clog2(MAX_ELEMENTS + 1) : COUNT_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_UL   = 3'd3;
  localparam logic [2:0] S_UP   = 3'd4;
  localparam logic [2:0] S_QA   = 3'd5;
  localparam logic [2:0] S_QB   = 3'd6;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata;

  logic [2:0]         state, state_next;
  logic [COUNT_W-1:0] element_count;
  in_word_t           cur;
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      node, node_next;
  logic [QW-1:0]      a, b, a_next, b_next, b_dec;
  logic [VALUE_W-1:0] acc, acc_next, acc_q, up_min;
  logic               rvalid, rvalid_next;
  logic               err, err_next;
  logic               finish;

  logic [CW-1:0]      count, first_x, last_x;
  logic               upd_ok, qry_bad;

  always_comb begin
    count   = (CW'(element_count) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS)
                                                       : CW'(element_count);
    first_x = CW'(cur.first_index);
    last_x  = CW'(cur.last_index);
    upd_ok  = first_x < count;
    qry_bad = (cur.first_index > cur.last_index) || (last_x >= count);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign in_ready = (state == S_IDLE);
  assign acc_q    = (rvalid && rdata < acc) ? rdata : acc;
  assign up_min   = (rdata < acc) ? rdata : acc;
  assign b_dec    = b[0] ? b - QW'(1) : b;
  assign finish   = (state == S_QA) && !(a < b) && (!out_valid || out_ready);

  always_comb begin
    state_next  = state;
    node_next   = node;
    a_next      = a;
    b_next      = b;
    acc_next    = acc;
    rvalid_next = 1'b0;
    err_next    = err;
    mem_we      = 1'b0;
    mem_waddr   = node;
    mem_wdata   = acc;
    mem_re      = 1'b0;
    mem_raddr   = node;
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (cur.cmd == CMD_UPDATE) begin
          node_next  = AW'(first_x) + AW'(MAX_ELEMENTS);
          acc_next   = cur.new_value;
          state_next = upd_ok ? S_UL : S_IDLE;
        end else begin
          acc_next   = VALUE_MAX;
          err_next   = qry_bad;
          a_next     = qry_bad ? '0 : QW'(first_x) + QW'(MAX_ELEMENTS);
          b_next     = qry_bad ? '0 : QW'(last_x) + QW'(MAX_ELEMENTS + 1);
          state_next = S_QA;
        end
      end
      S_UL: begin
        mem_we     = 1'b1;
        mem_waddr  = node;
        mem_wdata  = acc;
        mem_re     = 1'b1;
        mem_raddr  = node ^ AW'(1);
        state_next = S_UP;
      end
      S_UP: begin
        node_next = node >> 1;
        acc_next  = up_min;
        mem_we    = 1'b1;
        mem_waddr = node >> 1;
        mem_wdata = up_min;
        if ((node >> 1) == AW'(1)) begin
          state_next = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = (node >> 1) ^ AW'(1);
        end
      end
      S_QA: begin
        acc_next = acc_q;
        if (a < b) begin
          if (a[0]) begin
            mem_re      = 1'b1;
            mem_raddr   = AW'(a);
            rvalid_next = 1'b1;
            a_next      = a + QW'(1);
          end
          state_next = S_QB;
        end else if (finish) begin
          state_next = S_IDLE;
        end
      end
      S_QB: begin
        acc_next = acc_q;
        if (b[0]) begin
          mem_re      = 1'b1;
          mem_raddr   = AW'(b_dec);
          rvalid_next = 1'b1;
        end
        a_next     = a >> 1;
        b_next     = b_dec >> 1;
        state_next = S_QA;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      element_count <= COUNT_RESET;
      out_valid     <= 1'b0;
      rvalid        <= 1'b0;
      err           <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= rvalid_next;
      err    <= err_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_we) begin
        element_count <= cfg_data;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node <= node_next;
    a    <= a_next;
    b    <= b_next;
    acc  <= acc_next;
    if (in_valid && in_ready) begin
      cur <= in_data;
    end
    if (finish) begin
      out_data.min_value   <= err ? '0 : acc_q;
      out_data.range_error <= err;
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mem_we)
    else $error("tree write while idle");

  a_rw_distinct: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re && state != S_CLR) |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same node");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.range_error) |-> out_data.min_value == '0)
    else $error("range error with nonzero minimum");

  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input taken before clear pass");

endmodule

>>> tb/sv/range_min_check.sv
module range_min_check
  import rmst_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_word_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_word_t          out_data,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VALUE_W-1:0] tree_mins [0:2*MAX_ELEMENTS-1];
  logic [COUNT_W-1:0] elem_count;
  out_word_t          expected_q [$];

  function automatic int live_count();
    return (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
  endfunction

  function automatic void write_leaf(int pos, logic [VALUE_W-1:0] v);
    int node;
    node = pos + MAX_ELEMENTS;
    tree_mins[node] = v;
    while (node > 1) begin
      node = node >> 1;
      tree_mins[node] = (tree_mins[2*node] < tree_mins[2*node+1]) ?
                        tree_mins[2*node] : tree_mins[2*node+1];
    end
  endfunction

  function automatic logic [VALUE_W-1:0] span_min(int lo, int hi);
    logic [VALUE_W-1:0] best;
    int a;
    int b;
    best = VALUE_MAX;
    a = lo + MAX_ELEMENTS;
    b = hi + MAX_ELEMENTS + 1;
    while (a < b) begin
      if (a % 2 == 1) begin
        if (tree_mins[a] < best) best = tree_mins[a];
        a++;
      end
      if (b % 2 == 1) begin
        b--;
        if (tree_mins[b] < best) best = tree_mins[b];
      end
      a = a >> 1;
      b = b >> 1;
    end
    return best;
  endfunction

  function automatic out_word_t predict_query(in_word_t w);
    out_word_t r;
    if (w.first_index > w.last_index || w.last_index >= live_count()) begin
      r.min_value   = '0;
      r.range_error = 1'b1;
    end else begin
      r.min_value   = span_min(w.first_index, w.last_index);
      r.range_error = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int k = 0; k < 2*MAX_ELEMENTS; k++) tree_mins[k] = '0;
      elem_count = COUNT_RESET;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) elem_count = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: min_value %0d range_error %0b",
                     out_data.min_value, out_data.range_error);
        end else begin
          want = expected_q.pop_front();
          if (want.min_value !== out_data.min_value ||
              want.range_error !== out_data.range_error) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected min %0d err %0b, got min %0d err %0b",
                       want.min_value, want.range_error,
                       out_data.min_value, out_data.range_error);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_UPDATE) begin
          if (in_data.first_index < live_count())
            write_leaf(in_data.first_index, in_data.new_value);
        end else begin
          expected_q.push_back(predict_query(in_data));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/sv/range_minimum_segment_tree_tb.sv
module range_minimum_segment_tree_tb
  import rmst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 1024;
  localparam int LIMIT        = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int idle_count = 0;
  int current_count = 1024;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  int phase_counts [7] = '{1024, 13, 1, 2047, 256, 1000, 3};

  always #5 clk = ~clk;

  range_minimum_segment_tree #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  range_min_check #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_min_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return VALUE_W'($urandom() & VALUE_MAX);
    if (r < 80) return VALUE_W'($urandom_range(0, 50));
    if (r < 90) return VALUE_MAX - VALUE_W'($urandom_range(0, 50));
    return (r < 95) ? '0 : VALUE_MAX;
  endfunction

  task automatic send_word(input logic cmd, input int first, input int last,
                           input logic [VALUE_W-1:0] value);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.cmd         = cmd;
    in_data.first_index = first[IDX_W-1:0];
    in_data.last_index  = last[IDX_W-1:0];
    in_data.new_value   = value;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_count(input int c);
    settle();
    cfg_we   = 1'b1;
    cfg_data = c[COUNT_W-1:0];
    current_count = c;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_word();
    int live;
    int a;
    int b;
    int t;
    logic [VALUE_W-1:0] v;
    live = (current_count > MAX_ELEMENTS) ? MAX_ELEMENTS : current_count;
    v = pick_value();
    a = $urandom_range(0, 1023);
    b = $urandom_range(0, 1023);
    if ($urandom_range(0, 99) < 45) begin
      if (live > 0 && $urandom_range(0, 9) < 9) a = $urandom_range(0, live - 1);
      send_word(CMD_UPDATE, a, b, v);
    end else begin
      t = $urandom_range(0, 99);
      if (live > 0 && t < 85) begin
        a = $urandom_range(0, live - 1);
        b = $urandom_range(0, live - 1);
        if (t < 30) begin
          b = a + $urandom_range(0, 3);
          if (b > live - 1) b = live - 1;
        end
        if (t % 10 != 0 && a > b) {a, b} = {b, a};
      end else if (t < 93 && live < MAX_ELEMENTS) begin
        b = $urandom_range(live, 1023);
        a = $urandom_range(0, b);
      end
      send_word(CMD_QUERY, a, b, v);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      gap = gap_len();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // untouched tree reads zero, then extremes at both ends
    send_word(CMD_QUERY, 0, 1023, '0);
    send_word(CMD_UPDATE, 0, 1023, VALUE_MAX);
    send_word(CMD_UPDATE, 1023, 0, VALUE_MAX);
    send_word(CMD_QUERY, 0, 0, VALUE_MAX);
    send_word(CMD_QUERY, 1023, 1023, '0);
    send_word(CMD_QUERY, 0, 1023, '0);
    send_word(CMD_UPDATE, 682, 341, 31'h2AAAAAAA);
    send_word(CMD_UPDATE, 341, 682, 31'h55555555);
    send_word(CMD_QUERY, 682, 682, '0);
    send_word(CMD_QUERY, 341, 682, '0);
    send_word(CMD_QUERY, 1023, 0, '0);
    send_word(CMD_QUERY, 5, 4, '0);

    // shrink: past-the-end queries, ignored update
    set_count(6);
    send_word(CMD_UPDATE, 6, 0, 31'd1);
    send_word(CMD_UPDATE, 5, 0, 31'd3);
    send_word(CMD_QUERY, 0, 6, '0);
    send_word(CMD_QUERY, 0, 5, '0);
    send_word(CMD_QUERY, 6, 6, '0);

    // grow again: old elements come back
    set_count(10);
    send_word(CMD_QUERY, 6, 6, '0);
    send_word(CMD_QUERY, 0, 9, '0);

    set_count(0);
    send_word(CMD_UPDATE, 0, 0, '0);
    send_word(CMD_QUERY, 0, 0, '0);

    set_count(2047);
    send_word(CMD_QUERY, 0, 1023, '0);
    send_word(CMD_QUERY, 1023, 1023, '0);

    foreach (phase_counts[p]) begin
      set_count(phase_counts[p]);
      no_idle = (p == 3);
      if (p == 1) begin
        // fill the block while results are held back
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (12) send_word(CMD_QUERY, $urandom_range(0, 6), 12, pick_value());
        no_idle = 1'b0;
      end
      for (int i = 0; i < 120; i++) begin
        if (p == 5 && i == 60) settle();
        random_word();
      end
    end
    no_idle = 1'b0;

    settle();
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
